// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the Q table update block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, skipped while reset is high.
`define SQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Clocked property, also checked during reset.
`define SQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== design/sqtu_pkg.sv =====
// Types, constants and helper functions of the SARSA Q table update block.
// No dependencies; imported by every module of the block but the RAM.
`default_nettype none

package sqtu_pkg;

  localparam int DIR_STATES  = 4;
  localparam int HEAD_STATES = 8;
  localparam int FOV_STATES  = 8;
  localparam int TABLE_DEPTH = DIR_STATES * HEAD_STATES * FOV_STATES;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam int DATA_W    = 32;           // Q16.16 value
  localparam int FRAC_W    = 16;
  localparam int ONE_Q16   = 65536;
  localparam int CLEAR_STEP = ONE_Q16 / 2; // obstacle level divided by two
  localparam int COEF_W    = 17;           // Q1.16 alpha and gamma
  localparam int MB_W      = 18;           // narrow multiplier operand, signed
  localparam int PROD_W    = DATA_W + MB_W;
  localparam int ACC_W     = 36;
  localparam int IN_DATA_W = 56;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_UPDATE = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE      = 3'd0,
    CFG_W_DIR_ZERO  = 3'd1,
    CFG_W_DIR_OTHER = 3'd2,
    CFG_W_HEADING   = 3'd3,
    CFG_W_VIEW      = 3'd4,
    CFG_W_CLEARANCE = 3'd5,
    CFG_LEARN_RATE  = 3'd6,
    CFG_DISCOUNT    = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_FETCH, ST_LOAD, ST_OFF,
    ST_REW0, ST_REW1, ST_REW2, ST_GAM, ST_SUM, ST_ALPHA, ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_HEAD, MUL_VIEW, MUL_CLEAR, MUL_GAMMA, MUL_ALPHA
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD_DIR, ACC_ADD, ACC_TD
  } acc_op_t;

  typedef enum logic [1:0] {
    OUT_RAM, OUT_LOAD, OUT_ZERO, OUT_UPD
  } out_sel_t;

  // Input item as packed on the slave tdata bus (last member in the lowest bits).
  typedef struct packed {
    logic [5:0]               pad;
    logic signed [DATA_W-1:0] load_value;
    logic [2:0]               next_fov;
    logic [2:0]               next_head;
    logic [1:0]               next_dir;
    logic [1:0]               obstacle_level;
    logic [2:0]               state_fov;
    logic [2:0]               state_head;
    logic [1:0]               state_dir;
  } in_item_t;

  typedef struct packed {
    logic                     table_enable;
    logic signed [DATA_W-1:0] weight_dir_zero;
    logic signed [DATA_W-1:0] weight_dir_nonzero;
    logic signed [DATA_W-1:0] weight_heading;
    logic signed [DATA_W-1:0] weight_view;
    logic signed [DATA_W-1:0] weight_clearance;
    logic [COEF_W-1:0]        learn_rate;
    logic [COEF_W-1:0]        discount;
  } cfg_t;

  // Sequencer to datapath controls.
  typedef struct packed {
    logic     take_item;
    logic     rd_next;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     cap_q;
    logic     cap_qnext;
    logic     out_load;
    out_sel_t out_sel;
  } ctl_t;

  function automatic int clamp_idx(input int v, input int count);
    return (v >= count) ? count - 1 : v;
  endfunction

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [1:0] d,
                                                   input logic [2:0] h,
                                                   input logic [2:0] f);
    int di;
    int hi;
    int fi;
    di = clamp_idx(int'(d), DIR_STATES);
    hi = clamp_idx(int'(h), HEAD_STATES);
    fi = clamp_idx(int'(f), FOV_STATES);
    return ADDR_W'((di * HEAD_STATES + hi) * FOV_STATES + fi);
  endfunction

  function automatic logic signed [MB_W-1:0] head_frac(input logic [2:0] h);
    int hi;
    hi = clamp_idx(int'(h), HEAD_STATES);
    return MB_W'((hi * ONE_Q16) / HEAD_STATES);
  endfunction

  function automatic logic signed [MB_W-1:0] fov_frac(input logic [2:0] f);
    int fi;
    fi = clamp_idx(int'(f), FOV_STATES);
    return MB_W'((fi * ONE_Q16) / FOV_STATES);
  endfunction

  function automatic logic signed [MB_W-1:0] clear_of(input logic [1:0] obs);
    return MB_W'(ONE_Q16 - int'(obs) * CLEAR_STEP);
  endfunction

  // Limit a Q1.16 coefficient to one.
  function automatic logic signed [MB_W-1:0] coef_of(input logic [COEF_W-1:0] c);
    return (c > COEF_W'(ONE_Q16)) ? MB_W'(ONE_Q16) : MB_W'(c);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (&v[ACC_W-1:DATA_W-1] || ~|v[ACC_W-1:DATA_W-1]) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/sarsa_q_table_update.sv =====
// SARSA Q table update, one item in flight. An update runs the reward, discount, difference,
// learning-rate and finish states, a read the read and fetch states, a load or disabled
// request only its finish state, which waits for the result side (one shared multiplier and
// one RAM read port: two table reads and five products in sequence). A waiting result sits
// in the output register while the next item is taken. Synchronous active-high reset clears
// the sequencer and output valid, presets the configuration; entries undefined till loaded.
`default_nettype none

module sarsa_q_table_update import sqtu_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // slave stream: request items
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  // tdata, low bit up: state_dir[2], state_head[3], state_fov[3], obstacle_level[2],
  // next_dir[2], next_head[3], next_fov[3], load_value[32], zero pad[6]
  input  wire logic [IN_DATA_W-1:0] s_tdata,
  input  wire logic [1:0]           s_tuser,   // req_type[2]
  input  wire logic                 s_tlast,   // terminal
  // master stream: result items
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  output      logic [DATA_W-1:0]    m_tdata,   // q_value[32]
  output      logic [0:0]           m_tuser,   // status[1]
  // configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [DATA_W-1:0]    cfg_wdata
);

  cfg_t              cfg;
  ctl_t              ctl;
  logic              out_free;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata;
  logic              ram_we;

  // Configuration registers; the user must write only while the block is idle: unenforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.table_enable       <= 1'b0;
      cfg.weight_dir_zero    <= '0;
      cfg.weight_dir_nonzero <= '0;
      cfg.weight_heading     <= '0;
      cfg.weight_view        <= '0;
      cfg.weight_clearance   <= '0;
      cfg.learn_rate         <= COEF_W'(6554);
      cfg.discount           <= COEF_W'(58982);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_ENABLE:      cfg.table_enable       <= cfg_wdata[0];
        CFG_W_DIR_ZERO:  cfg.weight_dir_zero    <= cfg_wdata;
        CFG_W_DIR_OTHER: cfg.weight_dir_nonzero <= cfg_wdata;
        CFG_W_HEADING:   cfg.weight_heading     <= cfg_wdata;
        CFG_W_VIEW:      cfg.weight_view        <= cfg_wdata;
        CFG_W_CLEARANCE: cfg.weight_clearance   <= cfg_wdata;
        CFG_LEARN_RATE:  cfg.learn_rate         <= cfg_wdata[COEF_W-1:0];
        CFG_DISCOUNT:    cfg.discount           <= cfg_wdata[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The finishing step may hand over its result when the output register is empty
  // or is being drained in this cycle.
  assign out_free = !m_tvalid || m_tready;

  // Write the table on a load and at the end of an update, together with the result.
  assign ram_we = ctl.out_load && (ctl.out_sel == OUT_LOAD || ctl.out_sel == OUT_UPD);

  sqtu_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_req       (s_tuser),
    .table_enable (cfg.table_enable),
    .out_free     (out_free),
    .in_ready     (s_tready),
    .ctl          (ctl)
  );

  sqtu_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cfg        (cfg),
    .in_data    (s_tdata),
    .in_last    (s_tlast),
    .out_ready  (m_tready),
    .rdata      (rdata),
    .raddr      (raddr),
    .waddr      (waddr),
    .wdata      (wdata),
    .out_valid  (m_tvalid),
    .out_data   (m_tdata),
    .out_status (m_tuser[0])
  );

  sqtu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// ===== design/sqtu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sqtu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/sqtu_ctrl.sv =====
// Sequencer of the Q table update block: steps the shared multiplier and accumulator.
// Depends on sqtu_pkg.
`default_nettype none

module sqtu_ctrl import sqtu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic [1:0] in_req,
  input  wire logic table_enable,
  input  wire logic out_free,
  output      logic in_ready,
  output      ctl_t ctl
);

  state_t state;
  state_t state_next;
  req_t   req;

  assign req = req_t'(in_req);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req == REQ_LOAD) begin
            state_next = ST_LOAD;
          end else if (!table_enable) begin
            state_next = ST_OFF;
          end else if (req == REQ_UPDATE) begin
            state_next = ST_REW0;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ:  state_next = ST_FETCH;
      ST_REW0:  state_next = ST_REW1;
      ST_REW1:  state_next = ST_REW2;
      ST_REW2:  state_next = ST_GAM;
      ST_GAM:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_ALPHA;
      ST_ALPHA: state_next = ST_FIN;
      ST_FETCH, ST_LOAD, ST_OFF, ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctl           = '0;
    ctl.mul_sel   = MUL_HEAD;
    ctl.acc_op    = ACC_HOLD;
    ctl.out_sel   = OUT_RAM;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        ctl.take_item = in_valid;
      end
      ST_READ: begin
      end
      ST_FETCH: begin
        ctl.out_load = out_free;
        ctl.out_sel  = OUT_RAM;
      end
      ST_LOAD: begin
        ctl.out_load = out_free;
        ctl.out_sel  = OUT_LOAD;
      end
      ST_OFF: begin
        ctl.out_load = out_free;
        ctl.out_sel  = OUT_ZERO;
      end
      ST_REW0: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_HEAD;
        ctl.acc_op  = ACC_LOAD_DIR;
      end
      ST_REW1: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_VIEW;
        ctl.acc_op  = ACC_ADD;
        ctl.rd_next = 1'b1;
        ctl.cap_q   = 1'b1;
      end
      ST_REW2: begin
        ctl.mul_en    = 1'b1;
        ctl.mul_sel   = MUL_CLEAR;
        ctl.acc_op    = ACC_ADD;
        ctl.cap_qnext = 1'b1;
      end
      ST_GAM: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_GAMMA;
        ctl.acc_op  = ACC_ADD;
      end
      ST_SUM: begin
        ctl.acc_op = ACC_TD;
      end
      ST_ALPHA: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_ALPHA;
      end
      ST_FIN: begin
        ctl.out_load = out_free;
        ctl.out_sel  = OUT_UPD;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/sqtu_datapath.sv =====
// Datapath of the Q table update block: item hold, shared multiplier, accumulator
// and result register. Depends on sqtu_pkg.
`default_nettype none

module sqtu_datapath import sqtu_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ctl_t                     ctl,
  input  wire cfg_t                     cfg,
  input  wire logic [IN_DATA_W-1:0]     in_data,
  input  wire logic                     in_last,
  input  wire logic                     out_ready,
  input  wire logic [DATA_W-1:0]        rdata,
  output      logic [ADDR_W-1:0]        raddr,
  output      logic [ADDR_W-1:0]        waddr,
  output      logic [DATA_W-1:0]        wdata,
  output      logic                     out_valid,
  output      logic [DATA_W-1:0]        out_data,
  output      logic                     out_status
);

  in_item_t                 item;
  logic                     terminal;
  logic signed [DATA_W-1:0] q_cur;
  logic signed [DATA_W-1:0] q_next;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic [ADDR_W-1:0]        cur_addr;
  logic [ADDR_W-1:0]        next_addr;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [ACC_W-1:0]  prod_drop;
  logic signed [DATA_W-1:0] td;
  logic signed [DATA_W-1:0] upd_result;

  assign cur_addr  = entry_addr(item.state_dir, item.state_head, item.state_fov);
  assign next_addr = entry_addr(item.next_dir, item.next_head, item.next_fov);
  assign raddr     = ctl.rd_next ? next_addr : cur_addr;
  assign waddr     = cur_addr;

  // Floor of the product over 2^16.
  assign prod_drop  = ACC_W'(prod >>> FRAC_W);
  assign td         = sat32(acc);
  assign upd_result = sat32(ACC_W'(q_cur) + prod_drop);
  assign wdata      = (ctl.out_sel == OUT_LOAD) ? item.load_value : upd_result;

  always_comb begin
    case (ctl.mul_sel)
      MUL_HEAD: begin
        mul_a = cfg.weight_heading;
        mul_b = head_frac(item.state_head);
      end
      MUL_VIEW: begin
        mul_a = cfg.weight_view;
        mul_b = fov_frac(item.state_fov);
      end
      MUL_CLEAR: begin
        mul_a = cfg.weight_clearance;
        mul_b = clear_of(item.obstacle_level);
      end
      MUL_GAMMA: begin
        mul_a = q_next;
        mul_b = coef_of(cfg.discount);
      end
      MUL_ALPHA: begin
        mul_a = td;
        mul_b = coef_of(cfg.learn_rate);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.take_item) begin
      item     <= in_item_t'(in_data);
      terminal <= in_last;
    end
    if (ctl.cap_q) begin
      q_cur <= rdata;
    end
    if (ctl.cap_qnext) begin
      q_next <= terminal ? '0 : rdata;
    end
    if (ctl.mul_en) begin
      prod <= mul_a * mul_b;
    end
    case (ctl.acc_op)
      ACC_LOAD_DIR: begin
        acc <= (item.state_dir == '0) ? ACC_W'(cfg.weight_dir_zero)
                                      : ACC_W'(cfg.weight_dir_nonzero);
      end
      ACC_ADD: acc <= acc + prod_drop;
      // reward saturates first, then the temporal difference is formed
      ACC_TD:  acc <= ACC_W'(sat32(acc)) + prod_drop - ACC_W'(q_cur);
      default: acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      case (ctl.out_sel)
        OUT_RAM: begin
          out_data   <= rdata;
          out_status <= 1'b0;
        end
        OUT_LOAD: begin
          out_data   <= item.load_value;
          out_status <= 1'b0;
        end
        OUT_ZERO: begin
          out_data   <= '0;
          out_status <= 1'b1;
        end
        default: begin
          out_data   <= upd_result;
          out_status <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/sqtu_checker.sv =====
// Port-level checker of the Q table update block, bound to the top level.
// Depends on sqtu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sqtu_checker import sqtu_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [IN_DATA_W-1:0] s_tdata,
  input wire logic [1:0]           s_tuser,
  input wire logic                 s_tlast,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [DATA_W-1:0]    m_tdata,
  input wire logic [0:0]           m_tuser,
  input wire logic                 cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_addr,
  input wire logic [DATA_W-1:0]    cfg_wdata
);

  // Hold a stalled result.
  `SQ_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

  // Reset leaves no result pending.
  `SQ_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid)

  // One item at a time: the block is busy right after taking one.
  `SQ_ASSERT(a_busy_after_take, clk, rst, (s_tvalid && s_tready) |=> !s_tready)

  // A disabled-table result carries zero.
  `SQ_ASSERT(a_off_zero, clk, rst, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))

  // A fresh result only comes from a busy cycle.
  `SQ_ASSERT(a_result_from_work, clk, rst, $rose(m_tvalid) |-> !$past(s_tready))

endmodule

bind sarsa_q_table_update sqtu_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the SARSA Q table update block.
// It drives request items, predicts each result with its own table model and checks them.
// Depends on sqtu_pkg and the RTL of sarsa_q_table_update.
`default_nettype none

module testbench import sqtu_pkg::*;;

  localparam logic [1:0] REQ_SPARE = 2'd3;  // unassigned code, served as a read
  localparam int GAP_MAX      = 10;
  localparam int HOLD_AFTER   = 400;   // results seen before the long receiver hold
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 1000;  // cycles without any handshake
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 250;
  localparam longint S32_MAX  = 64'sd2147483647;
  localparam longint S32_MIN  = -64'sd2147483648;

  typedef struct {
    logic [1:0] code;      // request code, travels on tuser
    logic       terminal;  // travels on tlast
    in_item_t   body;
  } q_request_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     status;
  } q_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata   = '0;
  logic [1:0]           s_tuser   = '0;
  logic                 s_tlast   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [DATA_W-1:0]    m_tdata;
  logic [0:0]           m_tuser;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr  = CFG_ENABLE;
  logic [DATA_W-1:0]    cfg_wdata = '0;

  sarsa_q_table_update i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block: table contents and register values as written.
  logic signed [DATA_W-1:0] q_entries [TABLE_DEPTH];
  logic                     table_on    = 1'b0;
  logic signed [DATA_W-1:0] w_dir_zero  = '0;
  logic signed [DATA_W-1:0] w_dir_other = '0;
  logic signed [DATA_W-1:0] w_heading   = '0;
  logic signed [DATA_W-1:0] w_view      = '0;
  logic signed [DATA_W-1:0] w_clearance = '0;
  logic [COEF_W-1:0]        alpha_reg   = 17'd6554;
  logic [COEF_W-1:0]        gamma_reg   = 17'd58982;

  // Stimulus bookkeeping: which entries have been loaded so far.
  bit         loaded [TABLE_DEPTH];
  int         loaded_slots[$];
  q_request_t pending[$];
  q_answer_t  due_answers[$];
  q_request_t offered;

  bit no_idle = 1'b0;   // set for phases that run back to back
  bit s_took  = 1'b0;   // handshake seen at the last rising edge
  bit m_took  = 1'b0;
  bit held    = 1'b0;
  int send_wait = 0;
  int take_wait = 0;
  int answers_seen = 0;
  int errors = 0;
  int n_loads = 0;
  int n_reads = 0;
  int n_updates = 0;
  int n_terminal = 0;
  int n_settings = 0;

  // The field widths equal the counts, so no index ever needs clamping.
  function automatic int slot_of(logic [1:0] d, logic [2:0] h, logic [2:0] f);
    return (int'(d) * HEAD_STATES + int'(h)) * FOV_STATES + int'(f);
  endfunction

  // Drop the fraction bits of a product, rounding towards minus infinity.
  function automatic longint floor16(longint v);
    return v >>> FRAC_W;
  endfunction

  function automatic longint clip32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Reward: weighted direction flag, heading and view fractions, and clearance;
  // obstacle level three gives a clearance of minus one half.
  function automatic longint reward_of(in_item_t b);
    longint head_part;
    longint view_part;
    longint clear_part;
    longint acc;
    head_part  = (longint'(b.state_head) * ONE_Q16) / HEAD_STATES;
    view_part  = (longint'(b.state_fov) * ONE_Q16) / FOV_STATES;
    clear_part = ONE_Q16 - longint'(b.obstacle_level) * (ONE_Q16 / 2);
    acc = (b.state_dir == 2'd0) ? longint'(w_dir_zero) : longint'(w_dir_other);
    acc += floor16(longint'(w_heading) * head_part);
    acc += floor16(longint'(w_view) * view_part);
    acc += floor16(longint'(w_clearance) * clear_part);
    return clip32(acc);
  endfunction

  // Work out the answer to one accepted request and advance the shadow table.
  function automatic q_answer_t answer_of(q_request_t r);
    q_answer_t a;
    int        here;
    longint    alpha;
    longint    gamma;
    longint    q_now;
    longint    q_next;
    longint    td;
    here = slot_of(r.body.state_dir, r.body.state_head, r.body.state_fov);
    a.value  = '0;
    a.status = 1'b0;
    if (r.code == REQ_LOAD) begin
      // a load writes even while the table is disabled
      a.value = r.body.load_value;
      q_entries[here] = r.body.load_value;
    end else if (!table_on) begin
      a.status = 1'b1;
    end else if (r.code == REQ_UPDATE) begin
      alpha = longint'(alpha_reg);
      gamma = longint'(gamma_reg);
      if (alpha > ONE_Q16) alpha = ONE_Q16;
      if (gamma > ONE_Q16) gamma = ONE_Q16;
      q_now  = longint'(q_entries[here]);
      q_next = r.terminal ? 64'sd0 :
               longint'(q_entries[slot_of(r.body.next_dir, r.body.next_head,
                                          r.body.next_fov)]);
      td = clip32(reward_of(r.body) + floor16(gamma * q_next) - q_now);
      a.value = DATA_W'(clip32(q_now + floor16(alpha * td)));
      q_entries[here] = a.value;
    end else begin
      // plain read, and the spare code behaves the same
      a.value = q_entries[here];
    end
    return a;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, GAP_MAX));
  endfunction

  // Signed value within plus or minus two to the given power.
  function automatic logic [31:0] near_zero(int bits);
    logic [31:0] v;
    v = $urandom_range(0, (32'd1 << bits) - 1);
    if ($urandom_range(0, 1) != 0) v = -v;
    return v;
  endfunction

  function automatic logic [31:0] load_pick();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: return $urandom();
      default: return near_zero(20);
    endcase
  endfunction

  function automatic void push_request(logic [1:0] code, int here, int there,
                                       logic term, logic [1:0] obs, logic [31:0] val);
    q_request_t r;
    r.code     = code;
    r.terminal = term;
    r.body     = '0;
    r.body.state_dir      = 2'(here / (HEAD_STATES * FOV_STATES));
    r.body.state_head     = 3'((here / FOV_STATES) % HEAD_STATES);
    r.body.state_fov      = 3'(here % FOV_STATES);
    r.body.next_dir       = 2'(there / (HEAD_STATES * FOV_STATES));
    r.body.next_head      = 3'((there / FOV_STATES) % HEAD_STATES);
    r.body.next_fov       = 3'(there % FOV_STATES);
    r.body.obstacle_level = obs;
    r.body.load_value     = val;
    if (code == REQ_LOAD && !loaded[here]) begin
      loaded[here] = 1'b1;
      loaded_slots = {loaded_slots, here};
    end
    pending = {pending, r};
  endfunction

  function automatic int some_loaded();
    return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
  endfunction

  // Mostly updates over loaded entries; reads and loads keep the table moving.
  // A terminal update never uses its next entry, so that one may point anywhere.
  function automatic void push_random();
    int         roll;
    logic       term;
    logic [1:0] code;
    roll = $urandom_range(0, 99);
    if (loaded_slots.size() == 0 || roll < 20) begin
      push_request(REQ_LOAD, $urandom_range(0, TABLE_DEPTH - 1),
                   $urandom_range(0, TABLE_DEPTH - 1), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)), load_pick());
    end else if (roll < 35) begin
      code = ($urandom_range(0, 3) == 0) ? REQ_SPARE : REQ_READ;
      push_request(code, some_loaded(), $urandom_range(0, TABLE_DEPTH - 1),
                   1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom());
    end else begin
      term = ($urandom_range(0, 3) == 0);
      push_request(REQ_UPDATE, some_loaded(),
                   term ? int'($urandom_range(0, TABLE_DEPTH - 1)) : some_loaded(),
                   term, 2'($urandom_range(0, 3)), $urandom());
    end
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
  endtask

  // Wait until nothing is queued, offered or outstanding.
  task automatic settle();
    do @(posedge clk);
    while (pending.size() != 0 || s_tvalid || due_answers.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ENABLE:      table_on    = val[0];
      CFG_W_DIR_ZERO:  w_dir_zero  = val;
      CFG_W_DIR_OTHER: w_dir_other = val;
      CFG_W_HEADING:   w_heading   = val;
      CFG_W_VIEW:      w_view      = val;
      CFG_W_CLEARANCE: w_clearance = val;
      CFG_LEARN_RATE:  alpha_reg   = val[COEF_W-1:0];
      CFG_DISCOUNT:    gamma_reg   = val[COEF_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain the block, then rewrite every register.
  task automatic apply_settings(bit busy, logic [31:0] en, logic [31:0] wz,
                                logic [31:0] wo, logic [31:0] wh, logic [31:0] wv,
                                logic [31:0] wc, logic [31:0] lr, logic [31:0] disc);
    settle();
    no_idle = busy;
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_W_DIR_ZERO, wz);
    write_reg(CFG_W_DIR_OTHER, wo);
    write_reg(CFG_W_HEADING, wh);
    write_reg(CFG_W_VIEW, wv);
    write_reg(CFG_W_CLEARANCE, wc);
    write_reg(CFG_LEARN_RATE, lr);
    write_reg(CFG_DISCOUNT, disc);
    n_settings++;
  endtask

  task automatic run_random(int n);
    repeat (n) push_random();
  endtask

  // Record handshakes and predict each accepted request on the edge it is taken.
  always @(posedge clk) begin
    s_took <= !rst && s_tvalid && s_tready;
    m_took <= !rst && m_tvalid && m_tready;
    if (!rst && s_tvalid && s_tready) begin
      due_answers = {due_answers, answer_of(offered)};
      if (offered.code == REQ_LOAD) begin
        n_loads++;
      end else if (offered.code == REQ_UPDATE) begin
        n_updates++;
        if (offered.terminal) n_terminal++;
      end else begin
        n_reads++;
      end
    end
  end

  // Request driver: hold an item until taken, then idle for a drawn gap.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait = 0;
    end else if (!(s_tvalid && !s_took)) begin
      if (s_took) send_wait = draw_gap();
      if (send_wait != 0) begin
        send_wait--;
        s_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        offered = pending.pop_front();
        s_tdata  <= offered.body;
        s_tuser  <= offered.code;
        s_tlast  <= offered.terminal;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: stall for a drawn gap after each item; once, hold off long
  // enough for the block to fill and push back on its input.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      take_wait = 0;
    end else begin
      if (m_took) begin
        if (!held && answers_seen >= HOLD_AFTER) begin
          take_wait = HOLD_CYCLES;
          held = 1'b1;
        end else begin
          take_wait = draw_gap();
        end
      end
      if (take_wait != 0) begin
        take_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result checker: compare each item with the oldest prediction.
  always @(posedge clk) begin : result_check
    q_answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      answers_seen++;
      if (due_answers.size() == 0) begin
        errors++;
        $display("%0t: result with none pending, expected nothing, actual %h/%b",
                 $time, m_tdata, m_tuser);
      end else begin
        want = due_answers.pop_front();
        if (m_tdata !== want.value) flag_mismatch("q_value", want.value, m_tdata);
        if (m_tuser[0] !== want.status) flag_mismatch("status", 32'(want.status),
                                                       32'(m_tuser));
      end
    end
  end

  // Abort if no handshake happens on either side for too long.
  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall = 0;
      else stall++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int a_base;
    int a_top;
    int a_mid;
    int a_edge;
    a_base = slot_of(2'd0, 3'd0, 3'd0);
    a_top  = slot_of(2'd3, 3'd7, 3'd7);
    a_mid  = slot_of(2'd1, 3'd3, 3'd5);
    a_edge = slot_of(2'd2, 3'd7, 3'd0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Table disabled after reset: loads still land, reads and updates answer
    // zero with the disabled status, the spare code too.
    push_request(REQ_LOAD, a_base, a_top, 1'b0, 2'd0, 32'h7FFF_FFFF);
    push_request(REQ_LOAD, a_top, a_base, 1'b0, 2'd0, 32'h8000_0000);
    push_request(REQ_LOAD, a_mid, a_base, 1'b0, 2'd0, 32'h0001_8000);
    push_request(REQ_LOAD, a_edge, a_base, 1'b0, 2'd0, 32'hFFFE_0000);
    push_request(REQ_READ, a_base, a_top, 1'b0, 2'd0, 32'h0);
    push_request(REQ_UPDATE, a_mid, a_base, 1'b0, 2'd1, 32'h0);
    push_request(REQ_SPARE, a_top, a_mid, 1'b1, 2'd3, 32'h0);

    // Enabled, hand-picked weights, half learning rate and a discount of one.
    apply_settings(1'b0, 32'd1, 32'h0001_0000, 32'hFFFF_8000, 32'h0002_0000,
                   32'h0000_4000, 32'h0003_0000, 32'h0000_8000, 32'h0001_0000);
    push_request(REQ_READ, a_base, a_mid, 1'b0, 2'd0, 32'h0);
    push_request(REQ_SPARE, a_top, a_mid, 1'b0, 2'd0, 32'h0);
    push_request(REQ_UPDATE, a_mid, a_top, 1'b1, 2'd3, 32'h0);   // terminal, level three
    push_request(REQ_UPDATE, a_mid, a_base, 1'b0, 2'd0, 32'h0);  // next entry at maximum
    push_request(REQ_UPDATE, a_base, a_top, 1'b0, 2'd2, 32'h0);  // direction zero
    push_request(REQ_UPDATE, a_top, a_top, 1'b0, 2'd1, 32'h0);   // next is itself
    push_request(REQ_UPDATE, a_edge, a_mid, 1'b1, 2'd0, 32'h0);
    push_request(REQ_READ, a_edge, a_base, 1'b0, 2'd0, 32'h0);
    push_request(REQ_LOAD, a_edge, a_base, 1'b0, 2'd0, 32'h0);
    push_request(REQ_UPDATE, a_edge, a_mid, 1'b0, 2'd2, 32'h0);

    // Small weights at the reset coefficients.
    apply_settings(1'b0, 32'd1, near_zero(18), near_zero(18), near_zero(18),
                   near_zero(18), near_zero(18), 32'd6554, 32'd58982);
    run_random(PHASE_ITEMS);

    // Largest weights, coefficients above one: updates exercise saturation.
    apply_settings(1'b1, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_FFFF, 32'h0001_FFFF);
    run_random(PHASE_ITEMS);

    // Most negative weights, zero coefficients: updates leave entries alone.
    apply_settings(1'b0, 32'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    run_random(PHASE_ITEMS);

    // Disabled again with a mixed workload.
    apply_settings(1'b0, 32'd0, near_zero(18), near_zero(18), near_zero(18),
                   near_zero(18), near_zero(18), 32'h0001_0000, 32'd0);
    run_random(PHASE_ITEMS);

    // Full-range weights and random coefficients.
    apply_settings(1'b0, 32'd1, $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom_range(0, ONE_Q16), $urandom_range(0, 32'h1FFFF));
    run_random(PHASE_ITEMS);

    // Back-to-back traffic, coefficients of one.
    apply_settings(1'b1, 32'd1, near_zero(20), near_zero(20), near_zero(20),
                   near_zero(20), near_zero(20), 32'h0001_0000, 32'h0001_0000);
    run_random(PHASE_ITEMS);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d loads, %0d reads, %0d updates (%0d terminal) over %0d settings",
             n_loads, n_reads, n_updates, n_terminal, n_settings);
    $display("checked %0d results, %0d mismatches", answers_seen, errors);
    if (errors == 0 && due_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
